/* rtl/tabular_q_learning_update_assert.svh */
// ----------------------------------------------------------------------------
// tabular q-learning update assertion macros
// shared concurrent assertion forms, removable with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef TABULAR_Q_LEARNING_UPDATE_ASSERT_SVH
`define TABULAR_Q_LEARNING_UPDATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TQLU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tqlu assertion failed");
// next-cycle implication
`define TQLU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tqlu assertion failed");
`else
`define TQLU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TQLU_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/tqlu_pkg.sv */
// ----------------------------------------------------------------------------
// tqlu_pkg
// types, constants and codes shared by the q-learning update block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tqlu_pkg;

   localparam int QSIZE_DEF       = 8;
   localparam int NUM_ACTIONS_DEF = 5;
   localparam int ADDR_W_MAX      = 16;
   localparam int ACT_W           = 3;
   localparam int DEFAULT_ACTION  = 4;

   localparam logic signed [31:0] FIX_MINUS_ONE = 32'shFFFF0000;

   // configuration register indexes
   localparam logic [2:0] CSR_LEARN_RATE     = 3'd0;
   localparam logic [2:0] CSR_DISCOUNT       = 3'd1;
   localparam logic [2:0] CSR_REWARD_FINISH  = 3'd2;
   localparam logic [2:0] CSR_REWARD_SUCCESS = 3'd3;
   localparam logic [2:0] CSR_REWARD_FAIL    = 3'd4;

   // outcome classes
   localparam logic [1:0] OUTCOME_FAIL    = 2'd0;
   localparam logic [1:0] OUTCOME_SUCCESS = 2'd1;
   localparam logic [1:0] OUTCOME_FINISH  = 2'd2;

   typedef struct packed {
      logic [15:0]        learn_rate;
      logic [15:0]        discount;
      logic signed [31:0] reward_finish;
      logic signed [31:0] reward_success;
      logic signed [31:0] reward_fail;
   } cfg_type;

   // one classified update job
   typedef struct packed {
      logic [ADDR_W_MAX-1:0] next_base;
      logic [ADDR_W_MAX-1:0] cur_addr;
      logic                  wr_ok;
      logic [1:0]            outcome;
   } job_type;

   typedef struct packed {
      logic clearing;
   } stat_type;

endpackage

/* rtl/tqlu_ram.sv */
// ----------------------------------------------------------------------------
// tqlu_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tqlu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/tqlu_front.sv */
// ----------------------------------------------------------------------------
// tqlu_front
// accepts request words, wraps coordinates and builds table addresses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tqlu_front import tqlu_pkg::*; #(
   parameter int QSIZE       = QSIZE_DEF,
   parameter int NUM_ACTIONS = NUM_ACTIONS_DEF
) (
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        req_tuser,
   input  logic        q_full,
   input  stat_type    stat,
   output logic        q_push,
   output job_type     q_job
);
   localparam logic [4:0]  QS5 = 5'(QSIZE);
   localparam logic [15:0] QS  = 16'(QSIZE);
   localparam logic [15:0] NA  = 16'(NUM_ACTIONS);

   // coordinate modulo table size
   function automatic logic [15:0] wrap(input logic [2:0] v);
      logic [4:0] r;
      r = {2'b00, v};
      for (int i = 0; i < 4; i++) begin
         if (r >= QS5) begin
            r = r - QS5;
         end
      end
      return {11'd0, r};
   endfunction

   function automatic logic [15:0] base(input logic a, input logic [2:0] x,
                                        input logic [2:0] y, input logic [2:0] u);
      logic [15:0] idx;
      idx = {15'd0, a};
      idx = idx * QS + wrap(x);
      idx = idx * QS + wrap(y);
      idx = idx * QS + wrap(u);
      return idx * NA;
   endfunction

   logic [2:0] act;

   assign act = req_tdata[11:9];

   // classify and address
   always_comb begin
      q_job.next_base = base(req_tuser, req_tdata[16:14], req_tdata[19:17],
                             req_tdata[22:20]);
      q_job.wr_ok     = ({13'd0, act} < NA);
      q_job.cur_addr  = base(req_tuser, req_tdata[2:0], req_tdata[5:3], req_tdata[8:6])
                        + (q_job.wr_ok ? {13'd0, act} : 16'd0);
      q_job.outcome   = req_tdata[13:12];
   end

   assign req_tready = !q_full && !stat.clearing;
   assign q_push     = req_tvalid && req_tready;
endmodule

/* rtl/tqlu_fifo.sv */
// ----------------------------------------------------------------------------
// tqlu_fifo
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tqlu_fifo import tqlu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output job_type pop_job
);
   job_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   // pointer and count update
   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_job;
      end
   end

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign pop_job = mem_ff[rp_ff];
endmodule

/* rtl/tqlu_back.sv */
// ----------------------------------------------------------------------------
// tqlu_back
// clears the table, scans for the greedy action, computes and writes back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tqlu_back import tqlu_pkg::*; #(
   parameter int QSIZE       = QSIZE_DEF,
   parameter int NUM_ACTIONS = NUM_ACTIONS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_empty,
   input  job_type     q_job,
   output logic        q_pop,
   output stat_type    stat,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata
);
   localparam int DEPTH = 2 * QSIZE * QSIZE * QSIZE * NUM_ACTIONS;
   localparam int AW    = $clog2(DEPTH);
   localparam int KW    = $clog2(NUM_ACTIONS + 1);
   localparam int DFLT  = (DEFAULT_ACTION < NUM_ACTIONS) ? DEFAULT_ACTION
                                                         : NUM_ACTIONS - 1;
   localparam logic [KW-1:0]    K_CUR  = KW'(NUM_ACTIONS);
   localparam logic [KW-1:0]    K_DFLT = KW'(DFLT);
   localparam logic [ACT_W-1:0] A_DFLT = ACT_W'(DFLT);
   localparam logic [AW-1:0]    A_LAST = AW'(DEPTH - 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_READ, S_WAIT, S_MUL_G, S_SUM_T, S_MUL_Q, S_MUL_T, S_DONE
   } state_type;

   state_type          state_ff, state_in;
   job_type            job_ff, job_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [KW-1:0]      k_ff, k_in, rd_k_ff, rd_k_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [ACT_W-1:0]   best_ff, best_in;
   logic               found_ff, found_in;
   logic signed [31:0] bestq_ff, bestq_in, dflt_ff, dflt_in, curq_ff, curq_in;
   logic signed [48:0] prod_ff, prod_in;
   logic signed [34:0] t_ff, t_in;
   logic signed [49:0] m1_ff, m1_in;
   logic signed [52:0] m2_ff, m2_in;
   logic               vld_ff, vld_in;
   logic [39:0]        dat_ff, dat_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [31:0]        wr_data, rd_data;
   logic signed [31:0] rdq, maxq, rew, nv;
   logic signed [49:0] rnd1;
   logic signed [53:0] acc, rnd2;
   logic signed [37:0] nv_w;

   tqlu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rdq  = signed'(rd_data);
   assign maxq = found_ff ? bestq_ff : dflt_ff;

   // reward by outcome class, anything unknown counts as fail
   always_comb begin
      case (job_ff.outcome)
         OUTCOME_FINISH:  rew = cfg.reward_finish;
         OUTCOME_SUCCESS: rew = cfg.reward_success;
         default:         rew = cfg.reward_fail;
      endcase
   end

   // rounding and saturation of the final sum
   always_comb begin
      rnd1 = {prod_ff[48], prod_ff} + 50'sd32768;
      acc  = {{4{m1_ff[49]}}, m1_ff} + {m2_ff[52], m2_ff};
      rnd2 = acc + 54'sd32768;
      nv_w = rnd2[53:16];
      if (nv_w > 38'sd2147483647) begin
         nv = 32'sh7FFFFFFF;
      end else if (nv_w < -38'sd2147483648) begin
         nv = 32'sh80000000;
      end else begin
         nv = nv_w[31:0];
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      clr_in    = clr_ff;
      k_in      = k_ff;
      rd_k_in   = k_ff;
      rd_vld_in = 1'b0;
      best_in   = best_ff;
      found_in  = found_ff;
      bestq_in  = bestq_ff;
      dflt_in   = dflt_ff;
      curq_in   = curq_ff;
      prod_in   = prod_ff;
      t_in      = t_ff;
      m1_in     = m1_ff;
      m2_in     = m2_ff;
      vld_in    = vld_ff && !rsp_tready;
      dat_in    = dat_ff;
      q_pop     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = job_ff.cur_addr[AW-1:0];
      wr_data   = nv;
      rd_addr   = (k_ff == K_CUR) ? job_ff.cur_addr[AW-1:0]
                                  : AW'(job_ff.next_base + {{(ADDR_W_MAX-KW){1'b0}}, k_ff});

      // read data returning from the ram
      if (rd_vld_ff) begin
         if (rd_k_ff == K_CUR) begin
            curq_in = rdq;
         end else begin
            if (rd_k_ff == K_DFLT) begin
               dflt_in = rdq;
            end
            if (rdq > bestq_ff) begin
               best_in  = ACT_W'(rd_k_ff);
               bestq_in = rdq;
               found_in = 1'b1;
            end
         end
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = 32'd0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == A_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               job_in   = q_job;
               k_in     = '0;
               best_in  = A_DFLT;
               bestq_in = FIX_MINUS_ONE;
               found_in = 1'b0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            rd_vld_in = 1'b1;
            k_in      = k_ff + 1'b1;
            if (k_ff == K_CUR) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_MUL_G;
         end
         S_MUL_G: begin
            prod_in  = signed'({1'b0, cfg.discount}) * maxq;
            state_in = S_SUM_T;
         end
         S_SUM_T: begin
            t_in     = {{3{rew[31]}}, rew} + {rnd1[49], rnd1[49:16]};
            state_in = S_MUL_Q;
         end
         S_MUL_Q: begin
            m1_in    = signed'({1'b0, 17'd65536 - {1'b0, cfg.learn_rate}}) * curq_ff;
            state_in = S_MUL_T;
         end
         S_MUL_T: begin
            m2_in    = signed'({2'b00, cfg.learn_rate}) * t_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!vld_ff || rsp_tready) begin
               wr_en    = job_ff.wr_ok;
               vld_in   = 1'b1;
               dat_in   = {5'd0, best_ff, job_ff.wr_ok ? nv : 32'sd0};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         rd_vld_ff <= 1'b0;
         vld_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         rd_vld_ff <= rd_vld_in;
         vld_ff    <= vld_in;
      end
      job_ff   <= job_in;
      k_ff     <= k_in;
      rd_k_ff  <= rd_k_in;
      best_ff  <= best_in;
      found_ff <= found_in;
      bestq_ff <= bestq_in;
      dflt_ff  <= dflt_in;
      curq_ff  <= curq_in;
      prod_ff  <= prod_in;
      t_ff     <= t_in;
      m1_ff    <= m1_in;
      m2_ff    <= m2_in;
      dat_ff   <= dat_in;
   end

   assign stat.clearing = (state_ff == S_CLEAR);
   assign rsp_tvalid    = vld_ff;
   assign rsp_tdata     = dat_ff;
endmodule

/* rtl/tabular_q_learning_update.sv */
// ----------------------------------------------------------------------------
// tabular_q_learning_update
// two-agent q-table update: greedy scan of the next state, then
// q = (1-a)q + a(r + g*maxq) in signed q16.16, written back and returned
// ----------------------------------------------------------------------------
// After reset the block zeroes all 2*QSIZE^3*NUM_ACTIONS table entries (5120 by
// default) through its single write port; req_tready stays low during that
// pass while csr writes are taken. Each word then takes one read per action
// of the next state and one of the visited entry through the table's read
// port, then four multiply/add stages and the write-back. A two-word queue in
// front and the output register let a new word be taken while a result waits.
`timescale 1ns / 1ps
`include "tabular_q_learning_update_assert.svh"
module tabular_q_learning_update import tqlu_pkg::*; #(
   parameter int QSIZE       = QSIZE_DEF,
   parameter int NUM_ACTIONS = NUM_ACTIONS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cur_x, cur_y, cur_unseen, taken_action, outcome, next_x, next_y,
   // next_unseen, zero pad
   input  logic [23:0] req_tdata,
   // agent
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // new_value, greedy_action, zero pad
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);
   cfg_type  cfg_ff, cfg_in;
   stat_type stat;
   job_type  push_job, pop_job;
   logic     q_push, q_pop, q_full, q_empty;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_LEARN_RATE:     cfg_in.learn_rate     = csr_wdata[15:0];
            CSR_DISCOUNT:       cfg_in.discount       = csr_wdata[15:0];
            CSR_REWARD_FINISH:  cfg_in.reward_finish  = csr_wdata;
            CSR_REWARD_SUCCESS: cfg_in.reward_success = csr_wdata;
            CSR_REWARD_FAIL:    cfg_in.reward_fail    = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.learn_rate     <= 16'd6554;
         cfg_ff.discount       <= 16'd58982;
         cfg_ff.reward_finish  <= '0;
         cfg_ff.reward_success <= '0;
         cfg_ff.reward_fail    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tqlu_front #(.QSIZE(QSIZE), .NUM_ACTIONS(NUM_ACTIONS)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .stat       (stat),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   tqlu_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .pop_job  (pop_job)
   );

   tqlu_back #(.QSIZE(QSIZE), .NUM_ACTIONS(NUM_ACTIONS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_job      (pop_job),
      .q_pop      (q_pop),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // checks
   `TQLU_ASSERT_IMP(a_no_accept_in_clear, clock, reset, stat.clearing, !req_tready)
   `TQLU_ASSERT_IMP(a_no_result_in_clear, clock, reset, stat.clearing, !rsp_tvalid)
   `TQLU_ASSERT_IMP(a_greedy_in_range, clock, reset, rsp_tvalid, {29'd0, rsp_tdata[34:32]} < NUM_ACTIONS)
   `TQLU_ASSERT_NXT(a_pop_leaves_fifo, clock, reset, q_full && !q_pop, !req_tready)
endmodule

/* bench/tabular_q_learning_update_tb.sv */
// ----------------------------------------------------------------------------
// tabular_q_learning_update_tb
// drives update words with random handshake gaps, predicts every result from
// a local copy of both q tables and the csr settings, checks each output word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tabular_q_learning_update_tb;
   import tqlu_pkg::*;

   localparam int QS = 8;
   localparam int NA = 5;
   localparam int WORDS = 2 * QS * QS * QS * NA;
   localparam int CYCLE_LIMIT = 900000;

   typedef struct packed {
      logic       agent;
      logic [2:0] cur_x, cur_y, cur_unseen, taken_action;
      logic [1:0] outcome;
      logic [2:0] next_x, next_y, next_unseen;
   } step_word_type;

   // laid out as on rsp_tdata: new_value low, greedy_action above it
   typedef struct packed {
      logic [2:0]         greedy_action;
      logic signed [31:0] new_value;
   } update_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [2:0] csr_addr = '0;
   logic [31:0] csr_wdata = '0;

   always #4 clock = ~clock;

   tabular_q_learning_update dut (.*);

   // predictor state
   logic signed [31:0] q_model [WORDS];
   cfg_type cfg_model;

   step_word_type pending_words[$];
   update_type    expected_updates[$];
   int errors = 0;
   int cycles = 0;
   int req_gap = 0;
   int rsp_gap = 0;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic longint round_q16(longint x);
      longint y;
      y = x + 32768;
      if (y >= 0) return y / 65536;
      return -((-y + 65535) / 65536);
   endfunction

   function automatic int entry_base(logic agent, logic [2:0] x, logic [2:0] y,
                                     logic [2:0] u);
      return ((((int'(agent) * QS + x) * QS + y) * QS) + u) * NA;
   endfunction

   // q update prediction, also advances the model table
   function automatic update_type predict_update(step_word_type w);
      update_type res;
      int nb, ci, best;
      longint bestq, maxq, qv, r, t, acc, nv;
      nb = entry_base(w.agent, w.next_x, w.next_y, w.next_unseen);
      best = DEFAULT_ACTION;
      bestq = -65536;
      for (int i = 0; i < NA; i++) begin
         if (longint'(q_model[nb + i]) > bestq) begin
            best = i;
            bestq = q_model[nb + i];
         end
      end
      maxq = q_model[nb + best];
      nv = 0;
      if (w.taken_action < NA) begin
         ci = entry_base(w.agent, w.cur_x, w.cur_y, w.cur_unseen) + w.taken_action;
         qv = q_model[ci];
         if (w.outcome == OUTCOME_FINISH) r = cfg_model.reward_finish;
         else if (w.outcome == OUTCOME_SUCCESS) r = cfg_model.reward_success;
         else r = cfg_model.reward_fail;
         t = r + round_q16(longint'({1'b0, cfg_model.discount}) * maxq);
         acc = (65536 - longint'({1'b0, cfg_model.learn_rate})) * qv
               + longint'({1'b0, cfg_model.learn_rate}) * t;
         nv = round_q16(acc);
         if (nv > 64'sd2147483647) nv = 64'sd2147483647;
         if (nv < -64'sd2147483648) nv = -64'sd2147483648;
         q_model[ci] = nv[31:0];
      end
      res.new_value = nv[31:0];
      res.greedy_action = best[2:0];
      return res;
   endfunction

   // driver, the word on the bus is always the head of the queue
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_updates = {expected_updates, predict_update(pending_words.pop_front())};
         end
         if (!(req_tvalid && !req_tready)) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               step_word_type nw;
               nw = pending_words[0];
               req_tvalid <= 1'b1;
               req_tuser <= nw.agent;
               req_tdata <= {nw.next_unseen, nw.next_y, nw.next_x, nw.outcome,
                             nw.taken_action, nw.cur_unseen, nw.cur_y, nw.cur_x};
               req_gap <= gap_len();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            update_type got, want;
            got = rsp_tdata[34:0];
            if (expected_updates.size() == 0) begin
               $error("unexpected word new_value %0d", got.new_value);
               errors = errors + 1;
            end else begin
               want = expected_updates.pop_front();
               if (got.new_value !== want.new_value) begin
                  $error("new_value expected %0d actual %0d", want.new_value,
                         got.new_value);
                  errors = errors + 1;
               end
               if (got.greedy_action !== want.greedy_action) begin
                  $error("greedy_action expected %0d actual %0d",
                         want.greedy_action, got.greedy_action);
                  errors = errors + 1;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_gap <= gap_len();
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_LEARN_RATE:     cfg_model.learn_rate = val[15:0];
         CSR_DISCOUNT:       cfg_model.discount = val[15:0];
         CSR_REWARD_FINISH:  cfg_model.reward_finish = val;
         CSR_REWARD_SUCCESS: cfg_model.reward_success = val;
         default:            cfg_model.reward_fail = val;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      wait (pending_words.size() == 0 && expected_updates.size() == 0);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_reward();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, 20) << 16;
         3: return -($urandom_range(0, 20) << 16);
         default: return $urandom;
      endcase
   endfunction

   // state coordinate drawn from a small corner most of the time, so
   // entries are revisited and the greedy scan sees learned values
   function automatic logic [2:0] coord();
      return ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 1));
   endfunction

   function automatic step_word_type rand_word();
      step_word_type w;
      w = 24'($urandom);
      w.cur_x = coord(); w.cur_y = coord(); w.cur_unseen = coord();
      w.next_x = coord(); w.next_y = coord(); w.next_unseen = coord();
      w.taken_action = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
      w.outcome = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      return w;
   endfunction

   initial begin
      step_word_type w;
      for (int i = 0; i < WORDS; i++) q_model[i] = '0;
      cfg_model.learn_rate = 16'd6554;
      cfg_model.discount = 16'd58982;
      cfg_model.reward_finish = '0;
      cfg_model.reward_success = '0;
      cfg_model.reward_fail = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, then extremes
      write_csr(CSR_REWARD_FINISH, 32'h00100000);
      write_csr(CSR_REWARD_SUCCESS, 32'h00010000);
      write_csr(CSR_REWARD_FAIL, 32'hFFFF0000);
      for (int i = 0; i < 8; i++) begin
         w = '0;
         w.agent = i[0];
         w.taken_action = 3'(i);
         w.outcome = 2'(i % 4);
         pending_words = {pending_words, w};   // same visited and next entry
      end
      w = '1; pending_words = {pending_words, w};
      w = '1; w.taken_action = 3'd0; w.outcome = OUTCOME_FINISH;
      pending_words = {pending_words, w};
      drain();
      write_csr(CSR_LEARN_RATE, 32'h0000FFFF);
      write_csr(CSR_DISCOUNT, 32'h0000FFFF);
      write_csr(CSR_REWARD_FINISH, 32'h7FFFFFFF);
      write_csr(CSR_REWARD_FAIL, 32'h80000000);
      for (int i = 0; i < 6; i++) begin
         w = '0;
         w.taken_action = 3'(i % 5);
         w.outcome = (i < 3) ? OUTCOME_FINISH : OUTCOME_FAIL;
         w.next_x = 3'd1;
         pending_words = {pending_words, w};
      end
      drain();
      write_csr(CSR_LEARN_RATE, 32'h0);
      write_csr(CSR_DISCOUNT, 32'h0);
      for (int i = 0; i < 4; i++) pending_words = {pending_words, rand_word()};
      drain();

      // random phases with fresh settings
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_LEARN_RATE, (ph == 7) ? 32'h0000FFFF : $urandom);
         write_csr(CSR_DISCOUNT, (ph == 6) ? 32'h0 : $urandom);
         write_csr(CSR_REWARD_FINISH, pick_reward());
         write_csr(CSR_REWARD_SUCCESS, pick_reward());
         write_csr(CSR_REWARD_FAIL, pick_reward());
         for (int i = 0; i < 125; i++) pending_words = {pending_words, rand_word()};
         drain();
      end

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
